@@ rtl/color_keyed_sprite_blitter_macros.svh @@
// assertion macros for the color keyed sprite blitter
// used by the rtl modules that carry concurrent checks, no other dependencies
`ifndef COLOR_KEYED_SPRITE_BLITTER_MACROS_SVH
`define COLOR_KEYED_SPRITE_BLITTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// check under clock, disabled while reset is asserted
`define CKSB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check under clock, active during reset as well
`define CKSB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CKSB_ASSERT(lbl, clk, rst_n, prop, msg)
`define CKSB_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/cksb_pkg.sv @@
// types and constants for the color keyed sprite blitter
// no dependencies
`default_nettype none

package cksb_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int CNT_W      = $clog2(MAX_DIM);
  localparam int DIM_W      = CNT_W + 1;
  localparam int ORG_W      = 14;
  localparam int POS_W      = ORG_W + 1;
  localparam int PCT_W      = 7;
  localparam int PCT_MAX    = 100;
  localparam int PROD_W     = $clog2(MAX_DIM * PCT_MAX + 1);
  localparam int KEY_W      = 24;
  localparam int PIX_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_KEY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PERCENT = 3'd7;

  typedef enum logic [1:0] {
    MODE_KEYED = 2'd0,
    MODE_COPY  = 2'd1,
    MODE_TINT  = 2'd2,
    MODE_FILL  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [PIX_W-1:0] pixel;
    logic             last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] screen_x;
    logic [CNT_W-1:0] screen_y;
    logic [PIX_W-1:0] pixel_out;
  } out_item_t;

  // clamped configuration as seen by the datapath
  typedef struct packed {
    logic [KEY_W-1:0]         key;
    logic [PIX_W-1:0]         fill;
    logic [DIM_W-1:0]         scr_w;
    logic [DIM_W-1:0]         scr_h;
    logic [DIM_W-1:0]         spr_w;
    logic signed [ORG_W-1:0]  org_x;
    logic signed [ORG_W-1:0]  org_y;
    logic [PROD_W-1:0]        vis_prod;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] x;
    logic [CNT_W-1:0] y;
    mode_t            mode;
    logic [PIX_W-1:0] pixel;
  } q_entry_t;

endpackage

`default_nettype wire

@@ rtl/cksb_cfg.sv @@
// configuration registers with clamping and visible width product
// depends on cksb_pkg
`default_nettype none

module cksb_cfg
  import cksb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  logic [KEY_W-1:0]  key_r;
  logic [PIX_W-1:0]  fill_r;
  logic [DIM_W-1:0]  scr_w_r;
  logic [DIM_W-1:0]  scr_h_r;
  logic [DIM_W-1:0]  spr_w_r;
  logic [ORG_W-1:0]  org_x_r;
  logic [ORG_W-1:0]  org_y_r;
  logic [PCT_W-1:0]  pct_r;
  logic [PROD_W-1:0] vis_prod_r;

  logic [DIM_W-1:0]        spr_w_cl;
  logic [PCT_W-1:0]        pct_cl;
  logic [DIM_W+PCT_W-1:0]  prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      fill_r  <= '0;
      scr_w_r <= DIM_W'(640);
      scr_h_r <= DIM_W'(480);
      spr_w_r <= DIM_W'(1);
      org_x_r <= '0;
      org_y_r <= '0;
      pct_r   <= PCT_W'(PCT_MAX);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLOR_KEY:     key_r   <= cfg_wdata[KEY_W-1:0];
        REG_FILL_COLOR:    fill_r  <= cfg_wdata[PIX_W-1:0];
        REG_SCREEN_WIDTH:  scr_w_r <= cfg_wdata[DIM_W-1:0];
        REG_SCREEN_HEIGHT: scr_h_r <= cfg_wdata[DIM_W-1:0];
        REG_SPRITE_WIDTH:  spr_w_r <= cfg_wdata[DIM_W-1:0];
        REG_ORIGIN_X:      org_x_r <= cfg_wdata[ORG_W-1:0];
        REG_ORIGIN_Y:      org_y_r <= cfg_wdata[ORG_W-1:0];
        REG_WIDTH_PERCENT: pct_r   <= cfg_wdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (spr_w_r == '0) begin
      spr_w_cl = DIM_W'(1);
    end else if (spr_w_r > DIM_MAX) begin
      spr_w_cl = DIM_MAX;
    end else begin
      spr_w_cl = spr_w_r;
    end
    pct_cl = (pct_r > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct_r;
    prod   = (DIM_W+PCT_W)'(spr_w_cl) * (DIM_W+PCT_W)'(pct_cl);
  end

  // product registered; the user must keep config stable while items flow, the block does not enforce it
  always_ff @(posedge clk) begin
    vis_prod_r <= prod[PROD_W-1:0];
  end

  always_comb begin
    cfg.key      = key_r;
    cfg.fill     = fill_r;
    cfg.scr_w    = (scr_w_r > DIM_MAX) ? DIM_MAX : scr_w_r;
    cfg.scr_h    = (scr_h_r > DIM_MAX) ? DIM_MAX : scr_h_r;
    cfg.spr_w    = spr_w_cl;
    cfg.org_x    = $signed(org_x_r);
    cfg.org_y    = $signed(org_y_r);
    cfg.vis_prod = vis_prod_r;
  end

endmodule

`default_nettype wire

@@ rtl/cksb_fifo.sv @@
// short queue between front and back parts
// depends on cksb_pkg and the assertion macro header
`default_nettype none

`include "color_keyed_sprite_blitter_macros.svh"

module cksb_fifo
  import cksb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire q_entry_t     push_data,
  input  wire logic         pop,
  output q_entry_t          pop_data,
  output logic              empty,
  output logic [FIFO_CW-1:0] count
);

  q_entry_t           mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + FIFO_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

  `CKSB_ASSERT(a_no_overflow, clk, rst_n, push && !pop |-> count_r != FIFO_CW'(FIFO_DEPTH), "queue overflow")
  `CKSB_ASSERT(a_no_underflow, clk, rst_n, pop |-> count_r != '0, "queue underflow")

endmodule

`default_nettype wire

@@ rtl/cksb_front.sv @@
// front part: accepts items, tracks sprite position, clips and keys
// depends on cksb_pkg and the assertion macro header
`default_nettype none

`include "color_keyed_sprite_blitter_macros.svh"

module cksb_front
  import cksb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cfg_t          cfg,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire in_item_t      in_data,
  input  wire logic [FIFO_CW-1:0] q_count,
  output logic               q_push,
  output q_entry_t           q_data
);

  logic             in_accept;
  logic [CNT_W-1:0] col_r;
  logic [CNT_W-1:0] row_r;
  logic [CNT_W-1:0] col_nxt;
  logic [CNT_W-1:0] row_nxt;
  logic [DIM_W-1:0] col_inc;

  logic             s1_valid_r;
  mode_t            s1_mode_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [CNT_W-1:0] s1_col_r;
  logic [CNT_W-1:0] s1_row_r;

  logic signed [POS_W-1:0] x_pos;
  logic signed [POS_W-1:0] y_pos;
  logic [DIM_W-1:0]        col_p1;
  logic [PROD_W-1:0]       col_x100;
  logic                    x_ok;
  logic                    y_ok;
  logic                    vis_ok;
  logic                    keyed_out;

  // room is reserved for the item held in the stage register
  assign in_stall  = (q_count + FIFO_CW'(s1_valid_r)) >= FIFO_CW'(FIFO_DEPTH);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    col_inc = {1'b0, col_r} + DIM_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_accept) begin
      if (in_data.last_pixel) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= cfg.spr_w) begin
        col_nxt = '0;
        row_nxt = row_r + CNT_W'(1);
      end else begin
        col_nxt = col_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode_r <= in_data.mode;
      s1_pix_r  <= in_data.pixel;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
    end
  end

  // classification of the held item
  always_comb begin
    x_pos    = POS_W'($signed(cfg.org_x)) + $signed({{(POS_W-CNT_W){1'b0}}, s1_col_r});
    y_pos    = POS_W'($signed(cfg.org_y)) + $signed({{(POS_W-CNT_W){1'b0}}, s1_row_r});
    x_ok     = !x_pos[POS_W-1] &&
               ({1'b0, x_pos[POS_W-2:0]} < POS_W'(cfg.scr_w));
    y_ok     = !y_pos[POS_W-1] &&
               ({1'b0, y_pos[POS_W-2:0]} < POS_W'(cfg.scr_h));
    col_p1   = {1'b0, s1_col_r} + DIM_W'(1);
    // col < floor(w * pct / 100) is the same as (col + 1) * 100 <= w * pct
    col_x100 = (PROD_W'(col_p1) << 6) + (PROD_W'(col_p1) << 5) + (PROD_W'(col_p1) << 2);
    if (s1_mode_r == MODE_KEYED || s1_mode_r == MODE_COPY) begin
      vis_ok = col_x100 <= cfg.vis_prod;
    end else begin
      vis_ok = {1'b0, s1_col_r} < cfg.spr_w;
    end
    keyed_out = (s1_mode_r != MODE_COPY) && (s1_pix_r[KEY_W-1:0] == cfg.key);
  end

  assign q_push       = s1_valid_r && x_ok && y_ok && vis_ok && !keyed_out;
  assign q_data.x     = x_pos[CNT_W-1:0];
  assign q_data.y     = y_pos[CNT_W-1:0];
  assign q_data.mode  = s1_mode_r;
  assign q_data.pixel = s1_pix_r;

  `CKSB_ASSERT(a_last_clears, clk, rst_n, in_accept && in_data.last_pixel |=> col_r == '0 && row_r == '0, "counters not cleared after last item")
  `CKSB_ASSERT(a_col_in_sprite, clk, rst_n, in_accept && !in_data.last_pixel && col_inc < cfg.spr_w |=> col_r == $past(col_inc[CNT_W-1:0]), "column did not step")

endmodule

`default_nettype wire

@@ rtl/cksb_back.sv @@
// back part: forms the written pixel and holds the output register
// depends on cksb_pkg
`default_nettype none

module cksb_back
  import cksb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      q_empty,
  input  wire q_entry_t  q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic             out_valid_r;
  logic             out_valid_nxt;
  out_item_t        out_data_r;
  logic [PIX_W-1:0] pix_val;

  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    case (q_data.mode)
      MODE_TINT: pix_val = {8'h00, q_data.pixel[23:16], 1'b0, q_data.pixel[15:9],
                            1'b0, q_data.pixel[7:1]};
      MODE_FILL: pix_val = cfg.fill;
      default:   pix_val = q_data.pixel;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r.screen_x  <= q_data.x;
      out_data_r.screen_y  <= q_data.y;
      out_data_r.pixel_out <= pix_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/color_keyed_sprite_blitter.sv @@
// path: a written item passes the front stage register, the queue and the output register
// throughput: one item per cycle; the front stage and 4-entry queue keep input moving
// while the output register is stalled, until the queue fills
// reset: synchronous active low; clears position counters, queue and valids,
// and loads the configuration reset values
`default_nettype none

module color_keyed_sprite_blitter
  import cksb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data
);

  cfg_t               cfg;
  logic               q_push;
  q_entry_t           q_wdata;
  logic               q_pop;
  q_entry_t           q_rdata;
  logic               q_empty;
  logic [FIFO_CW-1:0] q_count;

  cksb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cksb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  cksb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty),
    .count     (q_count)
  );

  cksb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ bench/color_keyed_sprite_blitter_tb.sv @@
// self-checking bench for the color keyed sprite blitter: predicts every clipped, keyed pixel
// write and compares each accepted output item against it; depends on cksb_pkg and the rtl top
`timescale 1ns / 1ps

module color_keyed_sprite_blitter_tb;
  import cksb_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_ITEMS = 640;

  class pixel_write_board;
    logic [KEY_W-1:0] trans_key;
    logic [PIX_W-1:0] fill_color;
    logic [DIM_W-1:0] screen_w;
    logic [DIM_W-1:0] screen_h;
    logic [DIM_W-1:0] sprite_w;
    logic [ORG_W-1:0] origin_x;
    logic [ORG_W-1:0] origin_y;
    logic [PCT_W-1:0] width_pct;
    int col_pos;
    int row_pos;
    out_item_t expected_writes[$];
    int fails;

    function new();
      trans_key = '0;
      fill_color = '0;
      screen_w = 640;
      screen_h = 480;
      sprite_w = 1;
      origin_x = '0;
      origin_y = '0;
      width_pct = PCT_W'(PCT_MAX);
      col_pos = 0;
      row_pos = 0;
      fails = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_COLOR_KEY:     trans_key = data[KEY_W-1:0];
        REG_FILL_COLOR:    fill_color = data[PIX_W-1:0];
        REG_SCREEN_WIDTH:  screen_w = data[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_h = data[DIM_W-1:0];
        REG_SPRITE_WIDTH:  sprite_w = data[DIM_W-1:0];
        REG_ORIGIN_X:      origin_x = data[ORG_W-1:0];
        REG_ORIGIN_Y:      origin_y = data[ORG_W-1:0];
        REG_WIDTH_PERCENT: width_pct = data[PCT_W-1:0];
        default: ;
      endcase
    endfunction

    function int sprite_cols();
      if (sprite_w == 0) return 1;
      if (sprite_w > MAX_DIM) return MAX_DIM;
      return int'(sprite_w);
    endfunction

    function int waiting();
      return expected_writes.size();
    endfunction

    // works out the frame buffer write caused by one sprite pixel, then steps the counters
    function void note_pixel(in_item_t it);
      int cols, lim_w, lim_h, pct, vis, x, y;
      out_item_t w;
      cols = sprite_cols();
      lim_w = (screen_w > MAX_DIM) ? MAX_DIM : int'(screen_w);
      lim_h = (screen_h > MAX_DIM) ? MAX_DIM : int'(screen_h);
      pct = (width_pct > PCT_MAX) ? PCT_MAX : int'(width_pct);
      vis = (it.mode == MODE_KEYED || it.mode == MODE_COPY) ? cols * pct / PCT_MAX : cols;
      x = int'($signed(origin_x)) + col_pos;
      y = int'($signed(origin_y)) + row_pos;
      if (x >= 0 && y >= 0 && x < lim_w && y < lim_h && col_pos < vis &&
          (it.mode == MODE_COPY || it.pixel[KEY_W-1:0] != trans_key)) begin
        w.screen_x = x[CNT_W-1:0];
        w.screen_y = y[CNT_W-1:0];
        case (it.mode)
          MODE_TINT: w.pixel_out = {8'h00, it.pixel[23:16], 1'b0, it.pixel[15:9],
                                    1'b0, it.pixel[7:1]};
          MODE_FILL: w.pixel_out = fill_color;
          default:   w.pixel_out = it.pixel;
        endcase
        expected_writes.push_back(w);
      end
      if (it.last_pixel) begin
        col_pos = 0;
        row_pos = 0;
      end else if (col_pos + 1 >= cols) begin
        col_pos = 0;
        row_pos = (row_pos + 1) % MAX_DIM;
      end else begin
        col_pos++;
      end
    endfunction

    task report(string msg);
      fails++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_write(out_item_t got);
      out_item_t want;
      if (expected_writes.size() == 0) begin
        report($sformatf("unexpected write x=%0d y=%0d data=%h",
                         got.screen_x, got.screen_y, got.pixel_out));
        return;
      end
      want = expected_writes.pop_front();
      if (got.screen_x !== want.screen_x)
        report($sformatf("screen_x %0d, wanted %0d", got.screen_x, want.screen_x));
      if (got.screen_y !== want.screen_y)
        report($sformatf("screen_y %0d, wanted %0d", got.screen_y, want.screen_y));
      if (got.pixel_out !== want.pixel_out)
        report($sformatf("pixel_out %h, wanted %h at (%0d,%0d)", got.pixel_out,
                         want.pixel_out, want.screen_x, want.screen_y));
    endtask

    task close_out();
      if (expected_writes.size() != 0)
        report($sformatf("%0d writes never arrived", expected_writes.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  pixel_write_board sb;
  logic [CFG_DATA_W-1:0] reg_image [8];
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;
  int random_items = 0;

  color_keyed_sprite_blitter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // output side: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_write(out_data);
  end

  function automatic logic [31:0] org_bits(int v);
    return {{(32 - ORG_W){1'b0}}, v[ORG_W-1:0]};
  endfunction

  // unused upper bits of a register write get random content now and then
  function automatic logic [31:0] with_junk(logic [31:0] v, int w);
    logic [31:0] junk;
    junk = $urandom;
    if ($urandom_range(0, 3) == 0)
      v = v | (junk & ~((32'h1 << w) - 1));
    return v;
  endfunction

  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom;
    if ($urandom_range(0, 3) == 0)
      p[KEY_W-1:0] = sb.trans_key;
    return p;
  endfunction

  task automatic send_pixel(mode_t m, logic [31:0] p, logic last);
    in_item_t it;
    it.mode = m;
    it.pixel = p;
    it.last_pixel = last;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(it);
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_config();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= reg_image[i];
      @(posedge clk);
      sb.write_reg(CFG_IDX_W'(i), reg_image[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic pick_config();
    int scr_w, scr_h, spr, ox, oy, pct;
    logic [31:0] key;
    case ($urandom_range(0, 9))
      0: scr_w = 0;
      1: scr_w = MAX_DIM;
      2: scr_w = 8191;
      3: scr_w = 640;
      default: scr_w = $urandom_range(1, 48);
    endcase
    case ($urandom_range(0, 9))
      0: scr_h = 0;
      1: scr_h = MAX_DIM;
      2: scr_h = 8191;
      3: scr_h = 480;
      default: scr_h = $urandom_range(1, 48);
    endcase
    case ($urandom_range(0, 11))
      0: ox = -8192;
      1: ox = 8191;
      default: ox = $urandom_range(0, ((scr_w > MAX_DIM) ? MAX_DIM : scr_w) + 40) - 24;
    endcase
    case ($urandom_range(0, 11))
      0: oy = -8192;
      1: oy = 8191;
      default: oy = $urandom_range(0, ((scr_h > MAX_DIM) ? MAX_DIM : scr_h) + 40) - 24;
    endcase
    case ($urandom_range(0, 11))
      0: spr = 0;
      1: spr = 8191;
      2: spr = MAX_DIM;
      3: spr = $urandom_range(17, 64);
      default: spr = $urandom_range(1, 16);
    endcase
    case ($urandom_range(0, 7))
      0: pct = 0;
      1: pct = PCT_MAX;
      2: pct = $urandom_range(101, 127);
      default: pct = $urandom_range(0, PCT_MAX);
    endcase
    case ($urandom_range(0, 5))
      0: key = 32'h0;
      1: key = 32'h00FF_FFFF;
      default: key = $urandom & 32'h00FF_FFFF;
    endcase
    reg_image[REG_COLOR_KEY] = with_junk(key, KEY_W);
    reg_image[REG_FILL_COLOR] = $urandom;
    reg_image[REG_SCREEN_WIDTH] = with_junk(scr_w, DIM_W);
    reg_image[REG_SCREEN_HEIGHT] = with_junk(scr_h, DIM_W);
    reg_image[REG_SPRITE_WIDTH] = with_junk(spr, DIM_W);
    reg_image[REG_ORIGIN_X] = with_junk(org_bits(ox), ORG_W);
    reg_image[REG_ORIGIN_Y] = with_junk(org_bits(oy), ORG_W);
    reg_image[REG_WIDTH_PERCENT] = with_junk(pct, PCT_W);
  endtask

  // one sprite in raster order, sometimes with mixed modes or a stray end marker
  task automatic send_sprite();
    int cols, count;
    mode_t m;
    bit mixed, closed;
    cols = sb.sprite_cols();
    m = mode_t'($urandom_range(0, 3));
    mixed = ($urandom_range(0, 4) == 0);
    closed = ($urandom_range(0, 9) != 0);
    count = (cols > 64) ? $urandom_range(1, 40) : cols * $urandom_range(1, 6);
    for (int k = 0; k < count; k++) begin
      send_pixel(mixed ? mode_t'($urandom_range(0, 3)) : m, rand_pixel(),
                 (closed && k == count - 1) || $urandom_range(0, 59) == 0);
      random_items++;
    end
  endtask

  task automatic stream_run(int n);
    for (int k = 0; k <= n; k++)
      send_pixel(mode_t'($urandom_range(0, 3)), rand_pixel(), k == n);
  endtask

  initial begin
    int phase, target;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: key of zero, one column wide sprite
    send_pixel(MODE_KEYED, 32'h0000_0000, 1'b0);
    send_pixel(MODE_COPY, 32'h0000_0000, 1'b0);
    send_pixel(MODE_TINT, 32'hFFFF_FFFF, 1'b0);
    send_pixel(MODE_FILL, 32'h1234_5678, 1'b0);
    send_pixel(MODE_KEYED, 32'hFF00_0000, 1'b1);

    // bottom right corner of the largest screen, percent above 100
    reg_image[REG_COLOR_KEY] = 32'h00FF_FFFF;
    reg_image[REG_FILL_COLOR] = 32'hFFFF_FFFF;
    reg_image[REG_SCREEN_WIDTH] = MAX_DIM;
    reg_image[REG_SCREEN_HEIGHT] = 32'h0000_1FFF;
    reg_image[REG_SPRITE_WIDTH] = 4;
    reg_image[REG_ORIGIN_X] = org_bits(4092);
    reg_image[REG_ORIGIN_Y] = org_bits(4095);
    reg_image[REG_WIDTH_PERCENT] = 32'h0000_007F;
    drain_idle();
    load_config();
    for (int k = 0; k < 8; k++)
      send_pixel(mode_t'(k % 4), (k % 2 == 0) ? 32'h80FF_FFFF : 32'h7F01_00FE, k == 7);

    // zero screen width clips all, zero sprite width acts as one
    reg_image[REG_SCREEN_WIDTH] = 0;
    reg_image[REG_SCREEN_HEIGHT] = 480;
    reg_image[REG_SPRITE_WIDTH] = 0;
    reg_image[REG_ORIGIN_X] = 0;
    reg_image[REG_ORIGIN_Y] = 0;
    reg_image[REG_WIDTH_PERCENT] = PCT_MAX;
    drain_idle();
    load_config();
    for (int k = 0; k < 3; k++)
      send_pixel(mode_t'(k), 32'h0101_0101, k == 2);

    // small screen, partial visible width, top row above the screen
    reg_image[REG_COLOR_KEY] = 32'h0012_3456;
    reg_image[REG_FILL_COLOR] = 32'hA5A5_A5A5;
    reg_image[REG_SCREEN_WIDTH] = 5;
    reg_image[REG_SCREEN_HEIGHT] = 3;
    reg_image[REG_SPRITE_WIDTH] = 5;
    reg_image[REG_ORIGIN_X] = org_bits(1);
    reg_image[REG_ORIGIN_Y] = org_bits(-1);
    reg_image[REG_WIDTH_PERCENT] = 50;
    drain_idle();
    load_config();
    for (int k = 0; k < 10; k++)
      send_pixel(mode_t'(k % 4), (k % 3 == 0) ? 32'hEE12_3456 : $urandom, k == 9);

    // one column sprite, rows enter the screen from above
    reg_image[REG_SCREEN_WIDTH] = 640;
    reg_image[REG_SCREEN_HEIGHT] = 480;
    reg_image[REG_SPRITE_WIDTH] = 1;
    reg_image[REG_ORIGIN_X] = org_bits(3);
    reg_image[REG_ORIGIN_Y] = org_bits(-20);
    reg_image[REG_WIDTH_PERCENT] = PCT_MAX;
    drain_idle();
    load_config();
    stream_run(40);

    // oversized limits clamp, widest sprite columns enter from the left
    reg_image[REG_SCREEN_WIDTH] = 32'h0000_1FFF;
    reg_image[REG_SCREEN_HEIGHT] = MAX_DIM;
    reg_image[REG_SPRITE_WIDTH] = 32'h0000_1FFF;
    reg_image[REG_ORIGIN_X] = org_bits(-20);
    reg_image[REG_ORIGIN_Y] = org_bits(0);
    reg_image[REG_WIDTH_PERCENT] = 99;
    drain_idle();
    load_config();
    stream_run(40);

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick_config();
      if (phase == 0) begin
        reg_image[REG_SCREEN_WIDTH] = 640;
        reg_image[REG_SCREEN_HEIGHT] = 480;
        reg_image[REG_SPRITE_WIDTH] = 8;
        reg_image[REG_ORIGIN_X] = 0;
        reg_image[REG_ORIGIN_Y] = 0;
        reg_image[REG_WIDTH_PERCENT] = PCT_MAX;
      end
      drain_idle();
      load_config();
      if (phase == 0)
        hold_off_req = 1'b1;
      if (random_items > RANDOM_ITEMS - 150)
        calm = 1'b1;
      target = random_items + 60;
      while (random_items < target) send_sprite();
      phase++;
    end

    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.close_out();
    if (sb.fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
